// ===== hdl/rbd_pkg.sv =====
// Shared widths, operation codes and cell control type for the ring buffer deque.
package rbd_pkg;

  localparam int FUNC_W   = 4;
  localparam int POS_W    = 9;
  localparam int WORD_W   = 32;
  localparam int FOUND_W  = 8;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 9;

  localparam int CAPACITY_DEF   = 256;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [FUNC_W-1:0] F_PUSH    = 4'd0;
  localparam logic [FUNC_W-1:0] F_UNSHIFT = 4'd1;
  localparam logic [FUNC_W-1:0] F_POP     = 4'd2;
  localparam logic [FUNC_W-1:0] F_SHIFT   = 4'd3;
  localparam logic [FUNC_W-1:0] F_GET     = 4'd4;
  localparam logic [FUNC_W-1:0] F_SET     = 4'd5;
  localparam logic [FUNC_W-1:0] F_REMOVE  = 4'd6;
  localparam logic [FUNC_W-1:0] F_INSERT  = 4'd7;
  localparam logic [FUNC_W-1:0] F_ROTATE  = 4'd8;
  localparam logic [FUNC_W-1:0] F_FIND    = 4'd9;
  localparam logic [FUNC_W-1:0] F_REVERSE = 4'd10;
  localparam logic [FUNC_W-1:0] F_CLEAR   = 4'd11;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  localparam logic [2:0] COP_HOLD    = 3'd0;
  localparam logic [2:0] COP_RING    = 3'd1;
  localparam logic [2:0] COP_LOAD    = 3'd2;
  localparam logic [2:0] COP_REMOVE  = 3'd3;
  localparam logic [2:0] COP_INSERT  = 3'd4;
  localparam logic [2:0] COP_ROT1    = 3'd5;
  localparam logic [2:0] COP_TAGINIT = 3'd6;
  localparam logic [2:0] COP_SWAP    = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic       phase;
  } cell_ctl_t;

endpackage

// ===== hdl/rbd_req_if.sv =====
// Request channel carrying one deque operation word.
interface rbd_req_if;
  logic                            valid;
  logic                            ready;
  logic [rbd_pkg::FUNC_W-1:0]      func;
  logic [rbd_pkg::POS_W-1:0]       position;
  logic [rbd_pkg::WORD_W-1:0]      value;
  logic signed [rbd_pkg::WORD_W-1:0] rotate_by;

  modport source (output valid, func, position, value, rotate_by, input ready);
  modport sink (input valid, func, position, value, rotate_by, output ready);
endinterface

// ===== hdl/rbd_rsp_if.sv =====
// Response channel carrying one deque result word.
interface rbd_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [rbd_pkg::WORD_W-1:0]   value_out;
  logic [rbd_pkg::FOUND_W-1:0]  found_at;
  logic [rbd_pkg::STATUS_W-1:0] status;
  logic [rbd_pkg::COUNT_W-1:0]  count;

  modport source (output valid, value_out, found_at, status, count, input ready);
  modport sink (input valid, value_out, found_at, status, count, output ready);
endinterface

// ===== hdl/rbd_cell.sv =====
// One storage cell of the ring: a data word and a sort tag, fed by its two neighbors.
module rbd_cell #(
  parameter int IDX = 0,
  parameter int AW  = 8,
  parameter int CW  = 9,
  parameter int DW  = 32
) (
  input  logic               clk,
  input  rbd_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]      pos,
  input  logic [CW-1:0]      cnt,
  input  logic [DW-1:0]      val,
  input  logic [DW-1:0]      head_data,
  input  logic [DW-1:0]      left_data,
  input  logic [AW-1:0]      left_tag,
  input  logic [DW-1:0]      right_data,
  input  logic [AW-1:0]      right_tag,
  output logic [DW-1:0]      data,
  output logic [AW-1:0]      tag
);
  import rbd_pkg::*;

  localparam logic [CW-1:0] ME      = CW'(IDX);
  localparam logic [CW:0]   ME_NEXT = (CW+1)'(IDX + 1);

  logic [CW:0] cnt_ext;
  logic        take_right;
  logic        take_left;

  assign cnt_ext = {1'b0, cnt};

  // Odd-even transposition: this cell pairs with its right neighbor when its parity matches.
  always_comb begin
    take_right = (ME[0] == ctl.phase) && (ME_NEXT < cnt_ext) && (tag < right_tag);
    take_left  = (ME != '0) && (ME[0] != ctl.phase) && (ME < cnt) && (left_tag < tag);
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      COP_RING: begin
        data <= right_data;
        tag  <= right_tag;
      end
      COP_LOAD: begin
        if (ME == '0) data <= val;
      end
      COP_REMOVE: begin
        if (ME >= pos && ME_NEXT < cnt_ext) data <= right_data;
      end
      COP_INSERT: begin
        if (ME == pos) data <= val;
        else if (ME > pos && ME <= cnt) data <= left_data;
      end
      COP_ROT1: begin
        if (ME_NEXT < cnt_ext) data <= right_data;
        else if (ME_NEXT == cnt_ext) data <= head_data;
      end
      COP_TAGINIT: begin
        tag <= AW'(IDX);
      end
      COP_SWAP: begin
        if (take_right) begin
          data <= right_data;
          tag  <= right_tag;
        end else if (take_left) begin
          data <= left_data;
          tag  <= left_tag;
        end
      end
      default: begin
      end
    endcase
  end
endmodule

// ===== hdl/rbd_div.sv =====
// Bit-serial remainder unit for reducing a rotation amount modulo the element count.
module rbd_div #(
  parameter int CW = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rbd_pkg::WORD_W-1:0]   dividend,
  input  logic [CW-1:0]                divisor,
  output logic                         busy,
  output logic [CW-1:0]                rem
);
  import rbd_pkg::*;

  localparam int NW = $clog2(WORD_W);

  logic [WORD_W-1:0] dvd;
  logic [NW-1:0]     n;
  logic [CW:0]       trial;

  assign trial = {rem, dvd[WORD_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      n    <= '0;
    end else if (start) begin
      busy <= 1'b1;
      n    <= '0;
      dvd  <= dividend;
      rem  <= '0;
    end else if (busy) begin
      dvd <= {dvd[WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) rem <= CW'(trial - {1'b0, divisor});
      else rem <= CW'(trial);
      n <= n + 1'b1;
      if (n == NW'(WORD_W - 1)) busy <= 1'b0;
    end
  end
endmodule

// ===== hdl/ring_buffer_deque.sv =====
// Ring buffer deque: a row of CAPACITY cells that shift data words to their neighbors. An item
// that uses the ring first turns it one step at a time to bring the addressed position to cell
// zero (up to CAPACITY-1 steps); push, unshift, pop, shift, get and set need only that turn.
// Remove turns twice (to the position, then back to the front). Insert, find, rotate and
// reverse first turn to the front; find then steps once per element scanned, reverse runs
// neighbor swaps, and rotate waits for a serial remainder unit (overlapping the turn) and then
// moves the words one place per step. Errors, clear, and rotate or reverse of fewer than two
// words do not use the ring. A finished word waits in an output register, and the next item
// is accepted while it waits.
module ring_buffer_deque #(
  parameter int CAPACITY   = rbd_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst,
  rbd_req_if.sink   req,
  rbd_rsp_if.source rsp
);
  import rbd_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = DATA_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEEK = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_ROT  = 3'd3;
  localparam logic [2:0] S_FIND = 3'd4;
  localparam logic [2:0] S_REV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]          state;
  logic [FUNC_W-1:0]   fq;
  logic [CW-1:0]       posq;
  logic [DW-1:0]       valq;
  logic                negq;
  logic                seek2;
  logic [AW-1:0]       at;
  logic [AW-1:0]       tgt;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       step;
  logic [CW-1:0]       kq;
  logic [DW-1:0]       vout;
  logic [AW-1:0]       found;
  logic [STATUS_W-1:0] stat;

  logic                ovalid;
  logic [DW-1:0]       o_value;
  logic [AW-1:0]       o_found;
  logic [STATUS_W-1:0] o_status;
  logic [CW-1:0]       o_count;

  logic [DW-1:0] cdata [CAPACITY];
  logic [AW-1:0] ctag  [CAPACITY];
  cell_ctl_t     ctl;
  logic [AW-1:0] at_inc;
  logic          at_last;
  logic          accept;
  logic          div_start;
  logic          div_busy;
  logic [CW-1:0] div_rem;
  logic [WORD_W-1:0] mag;
  logic [CW-1:0] k;
  logic          full;
  logic          pos_ge;
  logic          pos_gt;

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign at_inc   = (at == AW'(CAPACITY - 1)) ? '0 : at + 1'b1;
  assign at_last  = ((CW+1)'(at) + (CW+1)'(1)) == (CW+1)'(cnt);
  assign full     = ((CW+1)'(cnt) >= (CW+1)'(CAPACITY));
  assign pos_ge   = (32'(req.position) >= 32'(cnt));
  assign pos_gt   = (32'(req.position) > 32'(cnt));
  assign mag      = req.rotate_by[WORD_W-1] ? (~req.rotate_by + 1'b1) : req.rotate_by;
  assign div_start = accept && (req.func == F_ROTATE) && (cnt >= CW'(2));
  assign k        = (negq && div_rem != '0) ? cnt - div_rem : div_rem;

  rbd_div #(.CW(CW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(mag),
    .divisor (cnt),
    .busy    (div_busy),
    .rem     (div_rem)
  );

  always_comb begin
    ctl.op    = COP_HOLD;
    ctl.phase = step[0];
    case (state)
      S_SEEK: begin
        if (at != tgt) ctl.op = COP_RING;
        else begin
          case (fq)
            F_PUSH, F_UNSHIFT, F_SET: ctl.op = COP_LOAD;
            F_REMOVE: if (seek2) ctl.op = COP_REMOVE;
            F_INSERT: ctl.op = COP_INSERT;
            F_REVERSE: ctl.op = COP_TAGINIT;
            default: ctl.op = COP_HOLD;
          endcase
        end
      end
      S_ROT: if (step != kq) ctl.op = COP_ROT1;
      S_FIND: if (cdata[0] != valq && !at_last) ctl.op = COP_RING;
      S_REV: if (step != cnt) ctl.op = COP_SWAP;
      default: ctl.op = COP_HOLD;
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int L = (i == 0) ? CAPACITY - 1 : i - 1;
    localparam int R = (i == CAPACITY - 1) ? 0 : i + 1;
    rbd_cell #(.IDX(i), .AW(AW), .CW(CW), .DW(DW)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .pos       (posq),
      .cnt       (cnt),
      .val       (valq),
      .head_data (cdata[0]),
      .left_data (cdata[L]),
      .left_tag  (ctag[L]),
      .right_data(cdata[R]),
      .right_tag (ctag[R]),
      .data      (cdata[i]),
      .tag       (ctag[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      at     <= '0;
      cnt    <= '0;
      ovalid <= 1'b0;
    end else begin
      // A word finished in this cycle replaces the one leaving, so only clear outside S_DONE.
      if (ovalid && rsp.ready && state != S_DONE) ovalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            fq    <= req.func;
            posq  <= CW'(req.position);
            valq  <= DW'(req.value);
            negq  <= req.rotate_by[WORD_W-1];
            seek2 <= 1'b0;
            step  <= '0;
            vout  <= '0;
            found <= '0;
            stat  <= ST_OK;
            tgt   <= '0;
            state <= S_DONE;
            case (req.func)
              F_PUSH, F_UNSHIFT: begin
                if (full) stat <= ST_FULL;
                else begin
                  tgt   <= (req.func == F_PUSH) ? AW'(cnt) : AW'(CAPACITY - 1);
                  state <= S_SEEK;
                end
              end
              F_POP: begin
                if (cnt == '0) stat <= ST_EMPTY;
                else begin
                  tgt   <= AW'(cnt - 1'b1);
                  state <= S_SEEK;
                end
              end
              F_SHIFT: begin
                if (cnt == '0) stat <= ST_EMPTY;
                else state <= S_SEEK;
              end
              F_GET, F_SET, F_REMOVE: begin
                if (pos_ge) stat <= ST_RANGE;
                else begin
                  tgt   <= AW'(req.position);
                  state <= S_SEEK;
                end
              end
              F_INSERT: begin
                if (pos_gt) stat <= ST_RANGE;
                else if (full) stat <= ST_FULL;
                else state <= S_SEEK;
              end
              F_ROTATE, F_REVERSE: begin
                if (cnt >= CW'(2)) state <= S_SEEK;
              end
              F_FIND: begin
                if (cnt == '0) stat <= ST_NOTFOUND;
                else state <= S_SEEK;
              end
              F_CLEAR: cnt <= '0;
              default: begin
              end
            endcase
          end
        end
        S_SEEK: begin
          if (at != tgt) at <= at_inc;
          else begin
            state <= S_DONE;
            case (fq)
              F_PUSH: cnt <= cnt + 1'b1;
              F_UNSHIFT: begin
                // The new front sits just below the old one, so every position moves up one.
                cnt <= cnt + 1'b1;
                at  <= '0;
              end
              F_POP: begin
                vout <= cdata[0];
                cnt  <= cnt - 1'b1;
              end
              F_SHIFT: begin
                vout <= cdata[0];
                cnt  <= cnt - 1'b1;
                at   <= AW'(CAPACITY - 1);
              end
              F_GET: vout <= cdata[0];
              F_REMOVE: begin
                if (!seek2) begin
                  vout  <= cdata[0];
                  seek2 <= 1'b1;
                  tgt   <= '0;
                  state <= S_SEEK;
                end else cnt <= cnt - 1'b1;
              end
              F_INSERT: cnt <= cnt + 1'b1;
              F_ROTATE: state <= S_DIV;
              F_FIND: state <= S_FIND;
              F_REVERSE: state <= S_REV;
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            kq    <= k;
            step  <= '0;
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (step == kq) state <= S_DONE;
          else step <= step + 1'b1;
        end
        S_FIND: begin
          if (cdata[0] == valq) begin
            found <= at;
            state <= S_DONE;
          end else if (at_last) begin
            stat  <= ST_NOTFOUND;
            state <= S_DONE;
          end else at <= at_inc;
        end
        S_REV: begin
          if (step == cnt) state <= S_DONE;
          else step <= step + 1'b1;
        end
        S_DONE: begin
          if (!ovalid || rsp.ready) begin
            ovalid   <= 1'b1;
            o_value  <= vout;
            o_found  <= found;
            o_status <= stat;
            o_count  <= cnt;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid     = ovalid;
  assign rsp.value_out = WORD_W'(o_value);
  assign rsp.found_at  = FOUND_W'(o_found);
  assign rsp.status    = o_status;
  assign rsp.count     = COUNT_W'(o_count);

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (CW+1)'(cnt) <= (CW+1)'(CAPACITY))
    else $error("element count above capacity");

  a_at_range: assert property (@(posedge clk) disable iff (rst)
    32'(at) < 32'(CAPACITY))
    else $error("ring alignment out of range");

  a_div_rotate: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (fq == F_ROTATE) && (state == S_SEEK || state == S_DIV))
    else $error("remainder unit busy outside a rotate");

  a_rot_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROT) |-> (step <= kq) && (kq < cnt))
    else $error("rotate step count overrun");
endmodule
